// ----- sv/slcfp_pkg.sv -----
package slcfp_pkg;

    localparam int ByteW = 8;
    localparam int WordW = 16;
    localparam int KindW = 2;
    localparam int CfgIndexW = 2;

    localparam logic [WordW-1:0] CrcPoly = 16'h1021;

    localparam logic [ByteW-1:0] StartFirstReset = 8'hAA;
    localparam logic [ByteW-1:0] StartSecondReset = 8'h55;
    localparam logic [WordW-1:0] CrcSeedReset = 16'hFFFF;
    localparam logic [WordW-1:0] MaxLengthReset = 16'd1024;

    localparam logic [CfgIndexW-1:0] RegStartFirst = 2'd0;
    localparam logic [CfgIndexW-1:0] RegStartSecond = 2'd1;
    localparam logic [CfgIndexW-1:0] RegCrcSeed = 2'd2;
    localparam logic [CfgIndexW-1:0] RegMaxLength = 2'd3;

    typedef enum logic [KindW-1:0] {
        EV_PAYLOAD = 2'd0,
        EV_GOOD = 2'd1,
        EV_CRC_BAD = 2'd2,
        EV_TOO_LONG = 2'd3
    } event_kind_t;

    typedef struct packed {
        logic [ByteW-1:0] start_first;
        logic [ByteW-1:0] start_second;
        logic [WordW-1:0] crc_seed;
        logic [WordW-1:0] max_length;
    } cfg_t;

    function automatic logic [WordW-1:0] crc_update(
        input logic [WordW-1:0] crc_in,
        input logic [ByteW-1:0] data
    );
        logic [WordW-1:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int i = 0; i < ByteW; i++) begin
            if (crc[WordW-1])
            begin
                crc = {crc[WordW-2:0], 1'b0} ^ CrcPoly;
            end
            else
            begin
                crc = {crc[WordW-2:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// ----- sv/slcfp_parser.sv -----
module slcfp_parser
    import slcfp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             byte_valid,
    input  logic [ByteW-1:0] byte_in,
    output logic             slot_free,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [KindW-1:0] event_kind,
    output logic [ByteW-1:0] frame_type,
    output logic [WordW-1:0] frame_length,
    output logic [ByteW-1:0] data_byte,
    output logic [WordW-1:0] payload_index,
    output logic [WordW-1:0] received_crc
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SECOND,
        PH_TYPE,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD,
        PH_CRC_LO,
        PH_CRC_HI
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [ByteW-1:0] type_reg, type_next;
    logic [WordW-1:0] length_reg, length_next;
    logic [WordW-1:0] seen_reg, seen_next;
    logic [WordW-1:0] crc_reg, crc_next;
    logic [ByteW-1:0] crc_lo_reg, crc_lo_next;

    logic             out_valid_reg, out_valid_next;
    event_kind_t      kind_reg, kind_next;
    logic [ByteW-1:0] otype_reg, otype_next;
    logic [WordW-1:0] olen_reg, olen_next;
    logic [ByteW-1:0] odata_reg, odata_next;
    logic [WordW-1:0] oidx_reg, oidx_next;
    logic [WordW-1:0] orcrc_reg, orcrc_next;

    logic             fire;
    logic             emit;
    logic [WordW-1:0] crc_step;
    logic [WordW-1:0] seen_inc;
    logic [WordW-1:0] rx_crc;

    assign slot_free = !out_valid_reg || out_ready;
    assign fire = byte_valid && slot_free;
    assign crc_step = crc_update(crc_reg, byte_in);
    assign seen_inc = seen_reg + 16'd1;
    assign rx_crc = {byte_in, crc_lo_reg};

    always_comb
    begin
        phase_next = phase_reg;
        type_next = type_reg;
        length_next = length_reg;
        seen_next = seen_reg;
        crc_next = crc_reg;
        crc_lo_next = crc_lo_reg;
        emit = 1'b0;
        kind_next = kind_reg;
        odata_next = odata_reg;
        oidx_next = oidx_reg;
        orcrc_next = orcrc_reg;
        case (phase_reg)
            PH_HUNT:
            begin
                if (byte_in == cfg.start_first)
                begin
                    phase_next = PH_SECOND;
                end
            end
            PH_SECOND:
            begin
                if (byte_in == cfg.start_second)
                begin
                    phase_next = PH_TYPE;
                end
                else if (byte_in != cfg.start_first)
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_TYPE:
            begin
                type_next = byte_in;
                crc_next = crc_update(cfg.crc_seed, byte_in);
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                length_next = {8'h00, byte_in};
                crc_next = crc_step;
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                length_next = {byte_in, length_reg[ByteW-1:0]};
                crc_next = crc_step;
                seen_next = '0;
                if (length_next > cfg.max_length)
                begin
                    phase_next = PH_HUNT;
                    emit = 1'b1;
                    kind_next = EV_TOO_LONG;
                    odata_next = '0;
                    oidx_next = '0;
                    orcrc_next = '0;
                end
                else if (length_next == '0)
                begin
                    phase_next = PH_CRC_LO;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                crc_next = crc_step;
                seen_next = seen_inc;
                if (seen_inc >= length_reg)
                begin
                    phase_next = PH_CRC_LO;
                end
                emit = 1'b1;
                kind_next = EV_PAYLOAD;
                odata_next = byte_in;
                oidx_next = seen_reg;
                orcrc_next = '0;
            end
            PH_CRC_LO:
            begin
                crc_lo_next = byte_in;
                phase_next = PH_CRC_HI;
            end
            PH_CRC_HI:
            begin
                phase_next = PH_HUNT;
                emit = 1'b1;
                kind_next = (rx_crc == crc_reg) ? EV_GOOD : EV_CRC_BAD;
                odata_next = '0;
                oidx_next = '0;
                orcrc_next = rx_crc;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
        otype_next = type_next;
        olen_next = length_next;
        out_valid_next = fire ? emit : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            type_reg <= '0;
            length_reg <= '0;
            seen_reg <= '0;
            crc_reg <= CrcSeedReset;
            crc_lo_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                phase_reg <= phase_next;
                type_reg <= type_next;
                length_reg <= length_next;
                seen_reg <= seen_next;
                crc_reg <= crc_next;
                crc_lo_reg <= crc_lo_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            kind_reg <= kind_next;
            otype_reg <= otype_next;
            olen_reg <= olen_next;
            odata_reg <= odata_next;
            oidx_reg <= oidx_next;
            orcrc_reg <= orcrc_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign event_kind = kind_reg;
    assign frame_type = otype_reg;
    assign frame_length = olen_reg;
    assign data_byte = odata_reg;
    assign payload_index = oidx_reg;
    assign received_crc = orcrc_reg;

endmodule

// ----- sv/sof_length_crc16_frame_parser_top.sv -----
// Serial frame parser that takes one received byte per transfer and hunts for a
// two-byte start marker, then reads a type byte, a little-endian 16-bit length,
// the payload and a little-endian CRC-16 (polynomial 0x1021, MSB first, seeded
// from crc_seed and covering type, length and payload). Each payload byte comes
// out as its own transfer; the last CRC byte gives a good or mismatch verdict,
// and a length above max_length gives an error and restarts the hunt. A byte
// passes through an input register and the parsing and CRC logic into the
// result register, so one byte is taken every cycle as long as results are
// taken, and each result is held in the result register until it is taken.
// Registers are written through the cfg port and take effect at once.
module sof_length_crc16_frame_parser_top
    import slcfp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [WordW-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [ByteW-1:0]     rx_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [KindW-1:0]     event_kind,
    output logic [ByteW-1:0]     frame_type,
    output logic [WordW-1:0]     frame_length,
    output logic [ByteW-1:0]     data_byte,
    output logic [WordW-1:0]     payload_index,
    output logic [WordW-1:0]     received_crc
);

    cfg_t             cfg_reg;
    logic             in_valid_reg;
    logic [ByteW-1:0] in_byte_reg;
    logic             slot_free;

    assign cfg_ready = 1'b1;
    assign in_ready = !in_valid_reg || slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_first <= StartFirstReset;
            cfg_reg.start_second <= StartSecondReset;
            cfg_reg.crc_seed <= CrcSeedReset;
            cfg_reg.max_length <= MaxLengthReset;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    RegStartFirst:  cfg_reg.start_first <= cfg_data[ByteW-1:0];
                    RegStartSecond: cfg_reg.start_second <= cfg_data[ByteW-1:0];
                    RegCrcSeed:     cfg_reg.crc_seed <= cfg_data;
                    RegMaxLength:   cfg_reg.max_length <= cfg_data;
                    default:        cfg_reg <= cfg_reg;
                endcase
            end
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    slcfp_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .byte_valid    (in_valid_reg),
        .byte_in       (in_byte_reg),
        .slot_free     (slot_free),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_kind    (event_kind),
        .frame_type    (frame_type),
        .frame_length  (frame_length),
        .data_byte     (data_byte),
        .payload_index (payload_index),
        .received_crc  (received_crc)
    );

endmodule

// ----- sim/frame_parser_checker.sv -----
package frame_crc_pkg;

    import slcfp_pkg::CrcPoly;

    function automatic logic [15:0] crc16_ccitt_byte(
        input logic [15:0] crc,
        input logic [7:0]  b
    );
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = acc[15] ^ b[i];
            acc = {acc[14:0], 1'b0};
            if (fb)
            begin
                acc = acc ^ CrcPoly;
            end
        end
        return acc;
    endfunction

endpackage

module frame_parser_checker
    import slcfp_pkg::*;
    import frame_crc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [WordW-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [ByteW-1:0]     rx_byte,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [KindW-1:0]     event_kind,
    input  logic [ByteW-1:0]     frame_type,
    input  logic [WordW-1:0]     frame_length,
    input  logic [ByteW-1:0]     data_byte,
    input  logic [WordW-1:0]     payload_index,
    input  logic [WordW-1:0]     received_crc,
    output int                   mismatches,
    output int                   events_awaited
);

    typedef enum logic [2:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        GET_TYPE,
        GET_LEN_LO,
        GET_LEN_HI,
        GET_PAYLOAD,
        GET_CRC_LO,
        GET_CRC_HI
    } parse_phase_e;

    typedef struct {
        event_kind_t      kind;
        logic [ByteW-1:0] ftype;
        logic [WordW-1:0] flen;
        logic [ByteW-1:0] data;
        logic [WordW-1:0] index;
        logic [WordW-1:0] rcrc;
    } parser_event_t;

    parser_event_t    awaited_events[$];

    logic [ByteW-1:0] marker_first;
    logic [ByteW-1:0] marker_second;
    logic [WordW-1:0] crc_seed;
    logic [WordW-1:0] length_limit;

    parse_phase_e     phase;
    logic [ByteW-1:0] held_type;
    logic [WordW-1:0] announced_len;
    logic [WordW-1:0] bytes_seen;
    logic [WordW-1:0] running_crc;
    logic [ByteW-1:0] crc_low;

    task automatic report(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic add_event(
        input event_kind_t      kind,
        input logic [ByteW-1:0] data,
        input logic [WordW-1:0] index,
        input logic [WordW-1:0] rcrc
    );
        parser_event_t ev;
        ev.kind = kind;
        ev.ftype = held_type;
        ev.flen = announced_len;
        ev.data = data;
        ev.index = index;
        ev.rcrc = rcrc;
        awaited_events.push_back(ev);
    endtask

    task automatic apply_write(input logic [CfgIndexW-1:0] idx, input logic [WordW-1:0] value);
        case (idx)
            RegStartFirst:  marker_first = value[ByteW-1:0];
            RegStartSecond: marker_second = value[ByteW-1:0];
            RegCrcSeed:     crc_seed = value;
            RegMaxLength:   length_limit = value;
            default:        ;
        endcase
    endtask

    task automatic predict_parse(input logic [ByteW-1:0] b);
        logic [WordW-1:0] rc;
        case (phase)
            HUNT_FIRST:
            begin
                if (b == marker_first)
                begin
                    phase = HUNT_SECOND;
                end
            end
            HUNT_SECOND:
            begin
                if (b == marker_second)
                begin
                    phase = GET_TYPE;
                end
                else if (b != marker_first)
                begin
                    phase = HUNT_FIRST;
                end
            end
            GET_TYPE:
            begin
                held_type = b;
                running_crc = crc16_ccitt_byte(crc_seed, b);
                phase = GET_LEN_LO;
            end
            GET_LEN_LO:
            begin
                announced_len = {8'h00, b};
                running_crc = crc16_ccitt_byte(running_crc, b);
                phase = GET_LEN_HI;
            end
            GET_LEN_HI:
            begin
                announced_len[15:8] = b;
                running_crc = crc16_ccitt_byte(running_crc, b);
                if (announced_len > length_limit)
                begin
                    add_event(EV_TOO_LONG, '0, '0, '0);
                    phase = HUNT_FIRST;
                end
                else
                begin
                    bytes_seen = '0;
                    phase = (announced_len != 0) ? GET_PAYLOAD : GET_CRC_LO;
                end
            end
            GET_PAYLOAD:
            begin
                running_crc = crc16_ccitt_byte(running_crc, b);
                add_event(EV_PAYLOAD, b, bytes_seen, '0);
                bytes_seen = bytes_seen + 1'b1;
                if (bytes_seen >= announced_len)
                begin
                    phase = GET_CRC_LO;
                end
            end
            GET_CRC_LO:
            begin
                crc_low = b;
                phase = GET_CRC_HI;
            end
            default:
            begin
                rc = {b, crc_low};
                add_event((rc == running_crc) ? EV_GOOD : EV_CRC_BAD, '0, '0, rc);
                phase = HUNT_FIRST;
            end
        endcase
    endtask

    task automatic check_event;
        parser_event_t want;
        if (awaited_events.size() == 0)
        begin
            report($sformatf("event kind %0d arrived with nothing expected", event_kind));
        end
        else
        begin
            want = awaited_events.pop_front();
            if (event_kind !== want.kind)
                report($sformatf("event_kind %0d, expected %0d", event_kind, want.kind));
            if (frame_type !== want.ftype)
                report($sformatf("frame_type %0h, expected %0h", frame_type, want.ftype));
            if (frame_length !== want.flen)
                report($sformatf("frame_length %0h, expected %0h", frame_length, want.flen));
            if (data_byte !== want.data)
                report($sformatf("data_byte %0h, expected %0h", data_byte, want.data));
            if (payload_index !== want.index)
                report($sformatf("payload_index %0h, expected %0h", payload_index, want.index));
            if (received_crc !== want.rcrc)
                report($sformatf("received_crc %0h, expected %0h", received_crc, want.rcrc));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaited_events.delete();
            mismatches = 0;
            events_awaited <= 0;
            marker_first = StartFirstReset;
            marker_second = StartSecondReset;
            crc_seed = CrcSeedReset;
            length_limit = MaxLengthReset;
            phase = HUNT_FIRST;
            held_type = '0;
            announced_len = '0;
            bytes_seen = '0;
            running_crc = CrcSeedReset;
            crc_low = '0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_event();
            end
            if (cfg_valid && cfg_ready)
            begin
                apply_write(cfg_index, cfg_data);
            end
            if (in_valid && in_ready)
            begin
                predict_parse(rx_byte);
            end
            events_awaited <= awaited_events.size();
        end
    end

endmodule

// ----- sim/sof_length_crc16_frame_parser_top_tb.sv -----
module sof_length_crc16_frame_parser_top_tb;

    import slcfp_pkg::*;
    import frame_crc_pkg::*;

    localparam int QuietLimit = 1000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CfgIndexW-1:0] cfg_index;
    logic [WordW-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [ByteW-1:0]     rx_byte;
    logic                 out_valid;
    logic                 out_ready;
    logic [KindW-1:0]     event_kind;
    logic [ByteW-1:0]     frame_type;
    logic [WordW-1:0]     frame_length;
    logic [ByteW-1:0]     data_byte;
    logic [WordW-1:0]     payload_index;
    logic [WordW-1:0]     received_crc;

    int                   mismatches;
    int                   events_awaited;
    int                   quiet_cycles;
    int                   bytes_sent;
    bit                   idle_on;
    bit                   calm;

    logic [ByteW-1:0]     marker_first;
    logic [ByteW-1:0]     marker_second;
    logic [WordW-1:0]     seed_now;
    logic [WordW-1:0]     length_limit;

    sof_length_crc16_frame_parser_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_kind    (event_kind),
        .frame_type    (frame_type),
        .frame_length  (frame_length),
        .data_byte     (data_byte),
        .payload_index (payload_index),
        .received_crc  (received_crc)
    );

    frame_parser_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_kind     (event_kind),
        .frame_type     (frame_type),
        .frame_length   (frame_length),
        .data_byte      (data_byte),
        .payload_index  (payload_index),
        .received_crc   (received_crc),
        .mismatches     (mismatches),
        .events_awaited (events_awaited)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QuietLimit)
            begin
                $display("%0t: no transfer for %0d cycles", $time, QuietLimit);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        out_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (idle_on && !calm && $urandom_range(0, 4) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
                out_ready = 1'b1;
            end
        end
    end

    task automatic push_byte(input logic [ByteW-1:0] b);
        if (idle_on && !calm && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        rx_byte = b;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic put_reg(input logic [CfgIndexW-1:0] idx, input logic [WordW-1:0] value);
        cfg_index = idx;
        cfg_data = value;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic configure(
        input logic [ByteW-1:0] first,
        input logic [ByteW-1:0] second,
        input logic [WordW-1:0] seed,
        input logic [WordW-1:0] limit
    );
        put_reg(RegStartFirst, {8'h00, first});
        put_reg(RegStartSecond, {8'h00, second});
        put_reg(RegCrcSeed, seed);
        put_reg(RegMaxLength, limit);
        cfg_valid = 1'b0;
        marker_first = first;
        marker_second = second;
        seed_now = seed;
        length_limit = limit;
    endtask

    task automatic wait_drained;
        in_valid = 1'b0;
        while (events_awaited != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic send_frame(
        input logic [ByteW-1:0] ftype,
        input logic [WordW-1:0] flen,
        input bit               crc_ok,
        input bit               repeat_first,
        input bit               alt_fill
    );
        logic [WordW-1:0] crc;
        logic [ByteW-1:0] b;
        int               i;
        push_byte(marker_first);
        if (repeat_first && marker_first != marker_second)
        begin
            push_byte(marker_first);
        end
        push_byte(marker_second);
        push_byte(ftype);
        push_byte(flen[7:0]);
        push_byte(flen[15:8]);
        crc = crc16_ccitt_byte(seed_now, ftype);
        crc = crc16_ccitt_byte(crc, flen[7:0]);
        crc = crc16_ccitt_byte(crc, flen[15:8]);
        if (flen <= length_limit)
        begin
            for (i = 0; i < flen; i++)
            begin
                b = alt_fill ? {8{i[0]}} : 8'($urandom);
                crc = crc16_ccitt_byte(crc, b);
                push_byte(b);
            end
            if (!crc_ok)
            begin
                crc = crc ^ 16'(1 << $urandom_range(0, 15));
            end
            push_byte(crc[7:0]);
            push_byte(crc[15:8]);
        end
    endtask

    function automatic logic [WordW-1:0] pick_length;
        int r;
        int cap;
        r = $urandom_range(0, 9);
        cap = (r < 6) ? 8 : ((r < 9) ? 40 : 300);
        if (cap > length_limit)
        begin
            cap = length_limit;
        end
        return WordW'($urandom_range(0, cap));
    endfunction

    function automatic logic [WordW-1:0] too_long_length;
        int r;
        r = $urandom_range(0, 3);
        if (r == 0)
        begin
            return length_limit + 1'b1;
        end
        else if (r == 1)
        begin
            return 16'hFFFF;
        end
        return WordW'($urandom_range(int'(length_limit) + 1, 16'hFFFF));
    endfunction

    function automatic logic [ByteW-1:0] hunt_noise;
        logic [ByteW-1:0] b;
        b = 8'($urandom);
        if (b == marker_first)
        begin
            b = ~b;
        end
        return b;
    endfunction

    function automatic logic [ByteW-1:0] non_marker;
        logic [ByteW-1:0] b;
        do
        begin
            b = 8'($urandom);
        end
        while (b == marker_first || b == marker_second);
        return b;
    endfunction

    task automatic run_random(input int count);
        int stop_at;
        int pick;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
        begin
            calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 68)
            begin
                send_frame(8'($urandom), pick_length(), $urandom_range(0, 3) != 0,
                           $urandom_range(0, 7) == 0, 1'b0);
            end
            else if (pick < 80 && length_limit != 16'hFFFF)
            begin
                send_frame(8'($urandom), too_long_length(), 1'b1, 1'b0, 1'b0);
            end
            else if (pick < 90)
            begin
                repeat ($urandom_range(1, 3)) push_byte(hunt_noise());
            end
            else
            begin
                push_byte(marker_first);
                push_byte(non_marker());
            end
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = RegStartFirst;
        cfg_data = '0;
        in_valid = 1'b0;
        rx_byte = '0;
        idle_on = 1'b1;
        calm = 1'b0;
        bytes_sent = 0;
        marker_first = StartFirstReset;
        marker_second = StartSecondReset;
        seed_now = CrcSeedReset;
        length_limit = MaxLengthReset;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // A stray byte after the first marker must send the parser back to hunting.
        push_byte(8'h00);
        push_byte(marker_first);
        push_byte(8'h13);
        send_frame(8'hFF, 16'd2, 1'b1, 1'b1, 1'b1);
        send_frame(8'h00, 16'd0, 1'b0, 1'b0, 1'b0);
        send_frame(8'h80, MaxLengthReset + 1'b1, 1'b1, 1'b0, 1'b0);
        run_random(170);

        wait_drained();
        configure(8'h00, 8'hFF, 16'h0000, 16'h0000);
        run_random(130);

        wait_drained();
        configure(8'hFF, 8'h00, 16'hFFFF, 16'hFFFF);
        run_random(170);

        // Identical markers advance on the second byte instead of waiting.
        wait_drained();
        configure(8'h7E, 8'h7E, 16'h1D0F, 16'd20);
        run_random(170);

        wait_drained();
        configure(8'($urandom), 8'($urandom), 16'($urandom), 16'hFFFE);
        send_frame(8'($urandom), 16'hFFFF, 1'b1, 1'b0, 1'b0);
        run_random(150);

        wait_drained();
        idle_on = 1'b0;
        configure(StartFirstReset, StartSecondReset, CrcSeedReset, 16'hFFFF);
        send_frame(8'h5A, 16'd40, 1'b1, 1'b0, 1'b0);
        run_random(60);

        wait_drained();
        repeat (8) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
